### rtl/core/ir_pulse_width_capture_unit_assert.svh
// assertion helpers shared by the capture unit
`ifndef IR_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH
`define IR_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH

// same-cycle implication
`define IRPW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irpw assertion failed");

// next-cycle implication
`define IRPW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irpw assertion failed");

`endif

### rtl/core/irpw_pkg.sv
`default_nettype none
package irpw_pkg;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_FALL    = 3'd1,
      REQ_RISE    = 3'd2,
      REQ_BOTH    = 3'd3,
      REQ_ENABLE  = 3'd4,
      REQ_DISABLE = 3'd5
   } req_kind_type;

   localparam logic [23:0] MAX_PULSE_RESET = 24'd131070;
   localparam logic [15:0] HALF_SAT        = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] now_us;
      logic        line_level;
      logic        tx_busy;
   } req_word_type;

   typedef struct packed {
      logic [15:0] pulse_code;
      logic [16:0] duration_us;
      logic        is_mark;
      logic        overlong;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic        in_mark;
      logic        reached_max;
      logic [31:0] pulse_start;
      logic        timeout_armed;
      logic        receiving;
   } state_type;

   // up to two result words from one request word, second only with first
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   function automatic rsp_word_type make_rsp(logic [15:0] half, logic mark, logic last);
      rsp_word_type r;
      r.pulse_code  = {half[15:1], mark};
      r.duration_us = {half[15:1], 2'b00};
      r.is_mark     = mark;
      r.overlong    = &half[15:1];
      r.last        = last;
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/irpw_calc.sv
`default_nettype none
module irpw_calc
   import irpw_pkg::*;
(
   input  wire req_word_type item,
   input  wire state_type    st,
   input  wire logic [23:0]  max_pulse_us,
   output state_type         st_next,
   output push_type          push
);

   logic [31:0] len;
   logic [32:0] rnd_sum;
   logic [31:0] rnd;
   logic [15:0] half;
   logic        first_evt;
   logic        second_evt;
   logic        emit0;
   logic        emit1;
   logic        first_mark;
   rsp_word_type r_first;
   rsp_word_type r_second;

   always_comb begin
      len     = item.now_us - st.pulse_start;
      rnd_sum = {1'b0, len} + 33'd2;
      rnd     = rnd_sum[32:1];
      half    = (|rnd[31:16]) ? HALF_SAT : rnd[15:0];
   end

   always_comb begin
      st_next    = st;
      first_evt  = 1'b0;
      second_evt = 1'b0;
      first_mark = st.in_mark;
      unique case (req_kind_type'(item.req_type))
         REQ_TICK: begin
            if (st.timeout_armed && (len >= {8'd0, max_pulse_us})) begin
               first_evt           = 1'b1;
               st_next.reached_max = 1'b1;
               st_next.timeout_armed = 1'b0;
            end
         end
         REQ_FALL: begin
            first_evt = st.receiving && !item.tx_busy && !st.in_mark;
         end
         REQ_RISE: begin
            first_evt = st.receiving && st.in_mark;
         end
         REQ_BOTH: begin
            // order follows the current level, so the second pulse has zero length
            first_evt  = st.receiving && (st.in_mark || !item.tx_busy);
            second_evt = st.receiving && !item.tx_busy;
         end
         REQ_ENABLE: begin
            st_next.receiving     = 1'b1;
            st_next.in_mark       = !item.line_level;
            st_next.pulse_start   = item.now_us;
            st_next.reached_max   = 1'b0;
            st_next.timeout_armed = 1'b1;
         end
         REQ_DISABLE: begin
            st_next.receiving     = 1'b0;
            st_next.timeout_armed = 1'b0;
         end
         default: begin
         end
      endcase

      if (first_evt && (req_kind_type'(item.req_type) != REQ_TICK)) begin
         // both edges leave the level where it was, a single edge toggles it
         st_next.in_mark       = second_evt ? st.in_mark : !st.in_mark;
         st_next.pulse_start   = item.now_us;
         st_next.reached_max   = 1'b0;
         st_next.timeout_armed = 1'b1;
      end
   end

   always_comb begin
      emit0    = first_evt && !st.reached_max;
      emit1    = second_evt;
      r_first  = make_rsp(half, first_mark, !emit1);
      r_second = make_rsp(16'd0, !first_mark, 1'b1);
      push.first_valid  = emit0 || emit1;
      push.second_valid = emit0 && emit1;
      push.first        = emit0 ? r_first : r_second;
      push.second       = r_second;
   end

endmodule
`default_nettype wire

### rtl/core/irpw_rsp_fifo.sv
`default_nettype none
module irpw_rsp_fifo
   import irpw_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire push_type     push,
   output logic              room2,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_word_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic [PTR_W-1:0]       wr_ptr_nx;
   logic                   pop;

   function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_nx = ptr_inc(wr_ptr_ff);
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = push.second_valid ? ptr_inc(wr_ptr_nx)
                : push.first_valid  ? wr_ptr_nx : wr_ptr_ff;
      count_in  = count_ff + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
                  - CNT_W'(pop);
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign room2     = (count_ff <= CNT_W'(DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_ptr_nx] <= push.second;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ir_pulse_width_capture_unit.sv
`default_nettype none
`include "ir_pulse_width_capture_unit_assert.svh"
// IR pulse width capture: times marks and spaces of an active-low receiver line from
// timestamped edge, time check, enable and disable words. A request word is taken into an
// input register and handled once the result queue has room for two words; one request word
// per cycle is sustained while it has that room. The first result word passes the input
// register and the result queue before it is offered on the rsp port. A word that ends two
// pulses (both edges at once) yields two result words, and the single result port delivers
// one word per cycle while rsp_ready is high; the RSP_DEPTH-entry queue absorbs the difference.
// The max_pulse_us register is written through the csr port, which is always ready.
module ir_pulse_width_capture_unit
   import irpw_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [23:0]  csr_wdata
);

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   state_type    st_ff, st_in;
   logic [23:0]  max_pulse_ff;
   state_type    st_calc;
   push_type     calc_push;
   push_type     push;
   logic         room2;
   logic         proc;
   logic         accept;

   irpw_calc u_calc (
      .item         (s1_word_ff),
      .st           (st_ff),
      .max_pulse_us (max_pulse_ff),
      .st_next      (st_calc),
      .push         (calc_push)
   );

   always_comb begin
      proc        = s1_valid_ff && room2;
      req_ready   = !s1_valid_ff || proc;
      accept      = req_valid && req_ready;
      s1_valid_in = accept || (s1_valid_ff && !proc);
      st_in       = proc ? st_calc : st_ff;
      push        = calc_push;
      push.first_valid  = proc && calc_push.first_valid;
      push.second_valid = proc && calc_push.second_valid;
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         st_ff        <= '0;
         max_pulse_ff <= MAX_PULSE_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         st_ff       <= st_in;
         if (csr_valid && csr_ready) begin
            max_pulse_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
   end

   irpw_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room2     (room2),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // an armed timeout always belongs to a pulse that has not been cut short
   `IRPW_ASSERT_IMP(a_armed_not_maxed, clock, reset, st_ff.timeout_armed, !st_ff.reached_max)
   `IRPW_ASSERT_IMP(a_stall_only_full, clock, reset, !req_ready, s1_valid_ff)
   `IRPW_ASSERT_NXT(a_disable_clears, clock, reset, proc && (s1_word_ff.req_type == REQ_DISABLE), !st_ff.receiving && !st_ff.timeout_armed)
   `IRPW_ASSERT_IMP(a_edges_need_rx, clock, reset, proc && !st_ff.receiving && (s1_word_ff.req_type != REQ_TICK), !push.first_valid)

endmodule
`default_nettype wire

### tb/sv/tb_ir_pulse_width_capture_unit.sv
`timescale 1ns / 1ps

module tb_ir_pulse_width_capture_unit;
   import irpw_pkg::*;

   // request codes with no function
   localparam logic [2:0] REQ_SPARE6 = 3'd6;
   localparam logic [2:0] REQ_SPARE7 = 3'd7;
   // rows whose results come from the predictor
   localparam int         PREDICTED  = -1;
   localparam logic [15:0] LEN_MASK  = 16'hFFFE;
   localparam logic [15:0] MARK_FLAG = 16'h0001;
   localparam int         NUM_PHASES = 6;
   localparam int         PHASE_WORDS = 185;

   typedef struct {
      req_word_type w;
      int           fixed_n;
      rsp_word_type fixed_rsp;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [23:0]  csr_wdata = '0;

   // predictor copy of the capture state
   logic         mark_now = 1'b0;
   logic         max_hit = 1'b0;
   logic [31:0]  start_us = '0;
   logic         armed = 1'b0;
   logic         rx_on = 1'b0;
   logic [23:0]  max_us = MAX_PULSE_RESET;
   rsp_word_type step_out [2];
   int           step_n;

   rsp_word_type pulse_q [$];
   stim_row_type word_plan_q [$];
   stim_row_type dir_rows [$];
   int           fault_cnt = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;
   int           stall_left = 0;
   bit           calm = 1'b0;
   logic [31:0]  stamp = '0;

   ir_pulse_width_capture_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic emit_len(logic [31:0] now, logic mark);
      logic [31:0]  len;
      logic [32:0]  sum;
      logic [31:0]  half;
      logic [15:0]  code;
      rsp_word_type r;
      len  = now - start_us;
      sum  = {1'b0, len} + 33'd2;
      half = sum[32:1];
      if (half > {16'd0, HALF_SAT}) begin
         half = {16'd0, HALF_SAT};
      end
      code = (half[15:0] & LEN_MASK) | (mark ? MARK_FLAG : 16'h0000);
      r.pulse_code  = code;
      r.duration_us = {1'b0, code & LEN_MASK} << 1;
      r.is_mark     = mark;
      r.overlong    = ((code & LEN_MASK) == LEN_MASK);
      r.last        = 1'b0;
      step_out[step_n] = r;
      step_n++;
   endtask

   task automatic close_pulse(logic [31:0] now, logic mark);
      if (!max_hit) begin
         emit_len(now, mark);
      end
      armed = 1'b0;
   endtask

   task automatic open_pulse(logic [31:0] now, logic mark);
      mark_now = mark;
      start_us = now;
      max_hit  = 1'b0;
      armed    = 1'b1;
   endtask

   task automatic fall_edge(logic [31:0] now, logic busy);
      if (!busy && !mark_now) begin
         close_pulse(now, 1'b0);
         open_pulse(now, 1'b1);
      end
   endtask

   task automatic rise_edge(logic [31:0] now);
      if (mark_now) begin
         close_pulse(now, 1'b1);
         open_pulse(now, 1'b0);
      end
   endtask

   task automatic predict_capture(req_word_type w);
      step_n = 0;
      case (w.req_type)
         REQ_TICK: begin
            if (armed && (w.now_us - start_us) >= {8'd0, max_us}) begin
               close_pulse(w.now_us, mark_now);
               max_hit = 1'b1;
            end
         end
         REQ_FALL: begin
            if (rx_on) fall_edge(w.now_us, w.tx_busy);
         end
         REQ_RISE: begin
            if (rx_on) rise_edge(w.now_us);
         end
         REQ_BOTH: begin
            // edge order follows the current line state
            if (rx_on && !mark_now) begin
               fall_edge(w.now_us, w.tx_busy);
               rise_edge(w.now_us);
            end else if (rx_on) begin
               rise_edge(w.now_us);
               fall_edge(w.now_us, w.tx_busy);
            end
         end
         REQ_ENABLE: begin
            rx_on = 1'b1;
            open_pulse(w.now_us, !w.line_level);
         end
         REQ_DISABLE: begin
            rx_on = 1'b0;
            armed = 1'b0;
         end
         default: begin
         end
      endcase
      if (step_n > 0) begin
         step_out[step_n - 1].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin : check_blk
      stim_row_type plan;
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            plan = word_plan_q.pop_front();
            predict_capture(req_word);
            if (plan.fixed_n == PREDICTED) begin
               for (int k = 0; k < step_n; k++) pulse_q.push_back(step_out[k]);
            end else if (plan.fixed_n > 0) begin
               pulse_q.push_back(plan.fixed_rsp);
            end
         end
         if (csr_valid && csr_ready) begin
            max_us = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (pulse_q.size() == 0) begin
               fault_cnt++;
               if (fault_cnt <= 10) begin
                  $display("unexpected result word: code %h dur %h mark %b over %b last %b",
                     rsp_word.pulse_code, rsp_word.duration_us, rsp_word.is_mark,
                     rsp_word.overlong, rsp_word.last);
               end
            end else begin
               want = pulse_q.pop_front();
               if (rsp_word.pulse_code !== want.pulse_code ||
                   rsp_word.duration_us !== want.duration_us ||
                   rsp_word.is_mark !== want.is_mark ||
                   rsp_word.overlong !== want.overlong ||
                   rsp_word.last !== want.last) begin
                  fault_cnt++;
                  if (fault_cnt <= 10) begin
                     $display("mismatch at %0t: expected code %h dur %h mark %b over %b last %b",
                        $realtime, want.pulse_code, want.duration_us, want.is_mark,
                        want.overlong, want.last);
                     $display("                  got code %h dur %h mark %b over %b last %b",
                        rsp_word.pulse_code, rsp_word.duration_us, rsp_word.is_mark,
                        rsp_word.overlong, rsp_word.last);
                  end
               end
            end
         end
      end
   end

   // result side stalls in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void add_row(logic [2:0] kind, logic [31:0] now, logic level,
                                   logic busy, int fixed_n, rsp_word_type fixed_rsp = '0);
      stim_row_type r;
      r.w.req_type   = kind;
      r.w.now_us     = now;
      r.w.line_level = level;
      r.w.tx_busy    = busy;
      r.fixed_n      = fixed_n;
      r.fixed_rsp    = fixed_rsp;
      dir_rows.push_back(r);
   endfunction

   task automatic send_word(stim_row_type r);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 9);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word_plan_q.push_back(r);
      req_word  <= r.w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pulse_q.size() != 0) @(posedge clock);
      // words that yield nothing may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max(logic [23:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stim_blk
      stim_row_type r;
      int           p;
      int unsigned  span;
      logic [31:0]  dt;
      logic [2:0]   kind;
      logic [23:0]  new_max;

      // nothing happens while disabled or unarmed
      add_row(REQ_TICK,    32'd0,          1'b0, 1'b0, 0);
      add_row(REQ_FALL,    32'd10,         1'b0, 1'b0, 0);
      add_row(REQ_BOTH,    32'd12,         1'b0, 1'b0, 0);
      add_row(REQ_SPARE6,  32'hFFFF_FFFF,  1'b1, 1'b1, 0);
      add_row(REQ_SPARE7,  32'd20,         1'b0, 1'b0, 0);
      add_row(REQ_ENABLE,  32'd100,        1'b1, 1'b0, 0);
      add_row(REQ_RISE,    32'd150,        1'b0, 1'b0, 0);
      add_row(REQ_FALL,    32'd110,        1'b0, 1'b1, 0);
      add_row(REQ_FALL,    32'd109,        1'b0, 1'b0, 1, '{16'd4, 17'd8, 1'b0, 1'b0, 1'b1});
      add_row(REQ_FALL,    32'd200,        1'b0, 1'b0, 0);
      add_row(REQ_RISE,    32'd109,        1'b0, 1'b0, 1, '{16'd1, 17'd0, 1'b1, 1'b0, 1'b1});
      add_row(REQ_BOTH,    32'd300,        1'b0, 1'b1, PREDICTED);
      add_row(REQ_BOTH,    32'd400,        1'b0, 1'b0, PREDICTED);
      add_row(REQ_FALL,    32'd500,        1'b0, 1'b0, PREDICTED);
      add_row(REQ_BOTH,    32'd700,        1'b0, 1'b1, PREDICTED);
      // timeout one short, then exactly at the maximum
      add_row(REQ_TICK,    32'd131769,     1'b0, 1'b0, PREDICTED);
      add_row(REQ_TICK,    32'd131770,     1'b0, 1'b0, 1,
              '{16'hFFFE, 17'h1FFFC, 1'b0, 1'b1, 1'b1});
      add_row(REQ_TICK,    32'd200000,     1'b0, 1'b0, PREDICTED);
      add_row(REQ_FALL,    32'd300000,     1'b0, 1'b0, PREDICTED);
      add_row(REQ_RISE,    32'hFFFF_FFF0,  1'b0, 1'b0, PREDICTED);
      // timestamp wrap and the longest possible pulse
      add_row(REQ_FALL,    32'h0000_0010,  1'b0, 1'b0, 1, '{16'd16, 17'd32, 1'b0, 1'b0, 1'b1});
      add_row(REQ_RISE,    32'h0000_000F,  1'b0, 1'b0, 1,
              '{16'hFFFF, 17'h1FFFC, 1'b1, 1'b1, 1'b1});
      add_row(REQ_ENABLE,  32'h0000_1000,  1'b0, 1'b0, 0);
      add_row(REQ_DISABLE, 32'h0000_2000,  1'b1, 1'b1, 0);
      add_row(REQ_RISE,    32'h0000_3000,  1'b0, 1'b0, 0);
      add_row(REQ_TICK,    32'hFFFF_FFFF,  1'b0, 1'b0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct  = 20;
      stall_pct = 15;
      foreach (dir_rows[i]) send_word(dir_rows[i]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            case (ph)
               1:       new_max = 24'd1;
               2:       new_max = 24'd0;
               3:       new_max = 24'hFF_FFFF;
               4:       new_max = 24'($urandom_range(2, 4000));
               default: new_max = 24'($urandom);
            endcase
            wait_drained();
            write_max(new_max);
         end
         idle_pct  = (ph == 3) ? 0 : 10 + 6 * ph;
         stall_pct = (ph == 4) ? 0 : 12 + 3 * ph;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (ph == NUM_PHASES - 1 && i == 35) calm = 1'b1;
            if (ph == 2 && i == 90) wait_drained();

            span = {8'd0, max_us};
            p = $urandom_range(0, 99);
            if (p < 50) dt = $urandom_range(0, 300);
            else if (p < 75) dt = $urandom_range(0, span + span / 8 + 2);
            else if (p < 85) dt = span - 1 + $urandom_range(0, 2);
            else if (p < 92) dt = '0;
            else dt = $urandom;
            stamp = stamp + dt;

            p = $urandom_range(0, 99);
            if (!rx_on && p < 60) kind = REQ_ENABLE;
            else if (p < 40) begin
               // mostly the edge that changes the line state
               if ($urandom_range(0, 3) != 0) kind = mark_now ? REQ_RISE : REQ_FALL;
               else kind = mark_now ? REQ_FALL : REQ_RISE;
            end
            else if (p < 52) kind = REQ_BOTH;
            else if (p < 80) kind = REQ_TICK;
            else if (p < 86) kind = REQ_ENABLE;
            else if (p < 90) kind = REQ_DISABLE;
            else if (p < 94) kind = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
            else kind = 3'($urandom_range(0, 7));

            r.w.req_type   = kind;
            r.w.now_us     = ($urandom_range(0, 99) < 4) ? $urandom : stamp;
            r.w.line_level = 1'($urandom_range(0, 1));
            r.w.tx_busy    = ($urandom_range(0, 99) < 15);
            r.fixed_n      = PREDICTED;
            r.fixed_rsp    = '0;
            send_word(r);
         end
      end
      req_valid <= 1'b0;

      for (int k = 0; k < 5000 && pulse_q.size() != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pulse_q.size() != 0) begin
         fault_cnt++;
         $display("%0d expected result words never arrived", pulse_q.size());
      end
      if (fault_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### ir_pulse_width_capture_unit.f
+incdir+rtl/core
rtl/core/irpw_pkg.sv
rtl/core/irpw_calc.sv
rtl/core/irpw_rsp_fifo.sv
rtl/core/ir_pulse_width_capture_unit.sv
tb/sv/tb_ir_pulse_width_capture_unit.sv
